### rtl/awarp_pkg.sv
// shared types and constants of the affine warp block
package awarp_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int FRAC_BITS  = 12;

   localparam int POS_W    = 9;
   localparam int COLOR_W  = 8;
   localparam int COEF_W   = 16;
   localparam int OFFSET_W = 28;
   localparam int SIZE_W   = 10;
   localparam int PROD_W   = COEF_W + POS_W + 1;
   localparam int SUM_W    = 30;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   typedef enum logic [2:0] {
      REG_COEF_XX,
      REG_COEF_XY,
      REG_COEF_YX,
      REG_COEF_YY,
      REG_OFFSET_X,
      REG_OFFSET_Y,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } awarp_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_ROUND,
      ST_READ,
      ST_OUT
   } awarp_state_type;

   typedef struct packed {
      logic signed [COEF_W-1:0]   coef_xx;
      logic signed [COEF_W-1:0]   coef_xy;
      logic signed [COEF_W-1:0]   coef_yx;
      logic signed [COEF_W-1:0]   coef_yy;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic [SIZE_W-1:0]          image_width;
      logic [SIZE_W-1:0]          image_height;
   } awarp_cfg_type;

   typedef struct packed {
      logic load_we;
      logic capture;
      logic mul_en;
      logic sum_en;
      logic round_en;
      logic read_en;
      logic out_load;
   } awarp_cmd_type;

endpackage

### rtl/awarp_if.sv
// valid/ready channel interfaces for requests and responses
interface awarp_req_if;
   logic                            valid;
   logic                            ready;
   logic                            action;
   logic [awarp_pkg::POS_W-1:0]     pos_x;
   logic [awarp_pkg::POS_W-1:0]     pos_y;
   logic [awarp_pkg::COLOR_W-1:0]   in_red;
   logic [awarp_pkg::COLOR_W-1:0]   in_green;
   logic [awarp_pkg::COLOR_W-1:0]   in_blue;

   modport source (output valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                   input ready);
   modport sink (input valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                 output ready);
endinterface

interface awarp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [awarp_pkg::COLOR_W-1:0]   out_red;
   logic [awarp_pkg::COLOR_W-1:0]   out_green;
   logic [awarp_pkg::COLOR_W-1:0]   out_blue;
   logic                            inside_res;

   modport source (output valid, out_red, out_green, out_blue, inside_res,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, inside_res,
                 output ready);
endinterface

### rtl/affine_warp_nearest_neighbor.sv
// affine warp top level: nearest-neighbor inverse mapping over a frame store
//
// loads (action 0) write one rgb pixel into the frame store, so a pixel stream
// can load at one transfer per clock while no query is in flight; loads outside
// the store are dropped. queries (action 1) map the output pixel back through
// the 2x2 q4.12 matrix plus q16.12 offset, round by trunc(v + 0.5) toward zero,
// and return the stored pixel, or zero with inside_res low when the source falls
// outside the image. a query holds the input side closed after its transfer
// while the controller walks the datapath stages one at a time: multiply, sum,
// round and bounds check, store read, result register. a finished result sits
// in the output register, and the next item is taken while it waits; a following
// query then holds in its result-register step, with the input side closed,
// until that result has been taken. the frame store is not cleared after reset:
// a query that hits a pixel never loaded returns whatever the memory holds.
// configuration goes through the apb-style port and must only be written while
// no query is in flight; the block itself does not enforce this.
module affine_warp_nearest_neighbor #(
   parameter int MAX_WIDTH  = awarp_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = awarp_pkg::MAX_HEIGHT,
   parameter int FRAC_BITS  = awarp_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   awarp_req_if.sink                     req_ch,
   awarp_rsp_if.source                   rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [awarp_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [awarp_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [awarp_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);

   awarp_pkg::awarp_cfg_type cfg;
   awarp_pkg::awarp_cmd_type cmd;

   // no wait states on the register port
   assign csr_pready = 1'b1;

   awarp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // controller: owns the handshakes and steps the datapath
   awarp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd)
   );

   // datapath: multipliers, adders, frame store, result register
   awarp_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .cfg        (cfg),
      .pos_x      (req_ch.pos_x),
      .pos_y      (req_ch.pos_y),
      .in_red     (req_ch.in_red),
      .in_green   (req_ch.in_green),
      .in_blue    (req_ch.in_blue),
      .out_red    (rsp_ch.out_red),
      .out_green  (rsp_ch.out_green),
      .out_blue   (rsp_ch.out_blue),
      .inside_res (rsp_ch.inside_res)
   );

`ifndef ASSERT_OFF
   // a query transfer blocks the input side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.action) |=> !req_ch.ready)
      else $error("input side open right after a query transfer");

   // a new result only appears as the controller leaves its busy phase
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result appeared without a query in flight");

   // an outside result carries a zero pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.inside_res) |->
         (rsp_ch.out_red == '0 && rsp_ch.out_green == '0 && rsp_ch.out_blue == '0))
      else $error("outside result with nonzero pixel");
`endif

endmodule

### rtl/awarp_csr.sv
// configuration register file behind the apb-style port
module awarp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [awarp_pkg::CSR_AW-1:0]      paddr,
   input  logic [awarp_pkg::CSR_DW-1:0]      pwdata,
   output logic [awarp_pkg::CSR_DW-1:0]      prdata,
   output awarp_pkg::awarp_cfg_type          cfg
);

   awarp_pkg::awarp_cfg_type cfg_ff, cfg_in;
   awarp_pkg::awarp_reg_type reg_sel;
   logic                     wr_en;

   assign reg_sel = awarp_pkg::awarp_reg_type'(paddr[awarp_pkg::CSR_AW-1:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            awarp_pkg::REG_COEF_XX:      cfg_in.coef_xx      = pwdata[15:0];
            awarp_pkg::REG_COEF_XY:      cfg_in.coef_xy      = pwdata[15:0];
            awarp_pkg::REG_COEF_YX:      cfg_in.coef_yx      = pwdata[15:0];
            awarp_pkg::REG_COEF_YY:      cfg_in.coef_yy      = pwdata[15:0];
            awarp_pkg::REG_OFFSET_X:     cfg_in.offset_x     = pwdata[27:0];
            awarp_pkg::REG_OFFSET_Y:     cfg_in.offset_y     = pwdata[27:0];
            awarp_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[9:0];
            awarp_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_xx      <= 16'sd4096;
         cfg_ff.coef_xy      <= '0;
         cfg_ff.coef_yx      <= '0;
         cfg_ff.coef_yy      <= 16'sd4096;
         cfg_ff.offset_x     <= '0;
         cfg_ff.offset_y     <= '0;
         cfg_ff.image_width  <= 10'd512;
         cfg_ff.image_height <= 10'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         awarp_pkg::REG_COEF_XX:      prdata = {16'b0, cfg_ff.coef_xx};
         awarp_pkg::REG_COEF_XY:      prdata = {16'b0, cfg_ff.coef_xy};
         awarp_pkg::REG_COEF_YX:      prdata = {16'b0, cfg_ff.coef_yx};
         awarp_pkg::REG_COEF_YY:      prdata = {16'b0, cfg_ff.coef_yy};
         awarp_pkg::REG_OFFSET_X:     prdata = {4'b0, cfg_ff.offset_x};
         awarp_pkg::REG_OFFSET_Y:     prdata = {4'b0, cfg_ff.offset_y};
         awarp_pkg::REG_IMAGE_WIDTH:  prdata = {22'b0, cfg_ff.image_width};
         awarp_pkg::REG_IMAGE_HEIGHT: prdata = {22'b0, cfg_ff.image_height};
         default:                     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/awarp_ctrl.sv
// sequencing state machine for loads and queries
module awarp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_action,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output awarp_pkg::awarp_cmd_type cmd
);

   awarp_pkg::awarp_state_type state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awarp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         awarp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action) begin
                  cmd.capture = 1'b1;
                  state_in    = awarp_pkg::ST_MUL;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         awarp_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = awarp_pkg::ST_SUM;
         end
         awarp_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = awarp_pkg::ST_ROUND;
         end
         awarp_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = awarp_pkg::ST_READ;
         end
         awarp_pkg::ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = awarp_pkg::ST_OUT;
         end
         awarp_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = awarp_pkg::ST_IDLE;
            end
         end
         default: state_in = awarp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/awarp_dp.sv
// mapping arithmetic, frame store and result register
module awarp_dp #(
   parameter int MAX_WIDTH  = awarp_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = awarp_pkg::MAX_HEIGHT,
   parameter int FRAC_BITS  = awarp_pkg::FRAC_BITS
) (
   input  logic                              clock,
   input  awarp_pkg::awarp_cmd_type          cmd,
   input  awarp_pkg::awarp_cfg_type          cfg,
   input  logic [awarp_pkg::POS_W-1:0]       pos_x,
   input  logic [awarp_pkg::POS_W-1:0]       pos_y,
   input  logic [awarp_pkg::COLOR_W-1:0]     in_red,
   input  logic [awarp_pkg::COLOR_W-1:0]     in_green,
   input  logic [awarp_pkg::COLOR_W-1:0]     in_blue,
   output logic [awarp_pkg::COLOR_W-1:0]     out_red,
   output logic [awarp_pkg::COLOR_W-1:0]     out_green,
   output logic [awarp_pkg::COLOR_W-1:0]     out_blue,
   output logic                              inside_res
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int SUM_W  = awarp_pkg::SUM_W;
   localparam int PROD_W = awarp_pkg::PROD_W;
   localparam int PIX_W  = 3 * awarp_pkg::COLOR_W;
   localparam logic [SUM_W-1:0] HALF      = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

   // trunc toward zero of s / 2^FRAC_BITS
   function automatic logic signed [SUM_W-1:0] trunc_q(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] fl;
      fl = s >>> FRAC_BITS;
      if (s[SUM_W-1] && ((s & FRAC_MASK) != '0)) begin
         trunc_q = fl + SUM_W'(1);
      end else begin
         trunc_q = fl;
      end
   endfunction

   logic [PIX_W-1:0]                 store_mem [DEPTH];

   logic [awarp_pkg::POS_W-1:0]      qx_ff, qy_ff;
   logic signed [awarp_pkg::POS_W:0] xs, ys;
   logic signed [PROD_W-1:0]         pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [PROD_W-1:0]         pxx_in, pxy_in, pyx_in, pyy_in;
   logic signed [SUM_W-1:0]          vx_ff, vy_ff, vx_in, vy_in;
   logic signed [SUM_W-1:0]          qx, qy, w_lim, h_lim;
   logic                             inside_in, inside_ff;
   logic [XW-1:0]                    sx_ff;
   logic [YW-1:0]                    sy_ff;
   logic [AW-1:0]                    rd_addr, wr_addr;
   logic                             wr_ok;
   logic [PIX_W-1:0]                 rd_data_ff;
   logic                             rd_inside_ff;
   logic [awarp_pkg::COLOR_W-1:0]    red_ff, green_ff, blue_ff;
   logic                             inside_res_ff;

   // load side
   assign wr_ok   = (32'(pos_x) < 32'(MAX_WIDTH)) && (32'(pos_y) < 32'(MAX_HEIGHT));
   assign wr_addr = AW'(32'(pos_y) * 32'(MAX_WIDTH) + 32'(pos_x));

   always_ff @(posedge clock) begin
      if (cmd.load_we && wr_ok) begin
         store_mem[wr_addr] <= {in_blue, in_green, in_red};
      end
   end

   // query position capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff <= pos_x;
         qy_ff <= pos_y;
      end
   end

   // products
   assign xs     = $signed({1'b0, qx_ff});
   assign ys     = $signed({1'b0, qy_ff});
   assign pxx_in = cfg.coef_xx * xs;
   assign pxy_in = cfg.coef_xy * ys;
   assign pyx_in = cfg.coef_yx * xs;
   assign pyy_in = cfg.coef_yy * ys;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         pxx_ff <= pxx_in;
         pxy_ff <= pxy_in;
         pyx_ff <= pyx_in;
         pyy_ff <= pyy_in;
      end
   end

   // sums with the rounding half folded in
   assign vx_in = SUM_W'(pxx_ff) + SUM_W'(pxy_ff) + SUM_W'(cfg.offset_x) + HALF;
   assign vy_in = SUM_W'(pyx_ff) + SUM_W'(pyy_ff) + SUM_W'(cfg.offset_y) + HALF;

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
      end
   end

   // truncation and bounds check
   assign qx    = trunc_q(vx_ff);
   assign qy    = trunc_q(vy_ff);
   assign w_lim = (32'(cfg.image_width) > 32'(MAX_WIDTH)) ?
                  SUM_W'(MAX_WIDTH) : SUM_W'(cfg.image_width);
   assign h_lim = (32'(cfg.image_height) > 32'(MAX_HEIGHT)) ?
                  SUM_W'(MAX_HEIGHT) : SUM_W'(cfg.image_height);
   assign inside_in = !qx[SUM_W-1] && (qx < w_lim) && !qy[SUM_W-1] && (qy < h_lim);

   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         sx_ff     <= qx[XW-1:0];
         sy_ff     <= qy[YW-1:0];
         inside_ff <= inside_in;
      end
   end

   // frame store read
   assign rd_addr = inside_ff ? AW'(32'(sy_ff) * 32'(MAX_WIDTH) + 32'(sx_ff)) : '0;

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_data_ff   <= store_mem[rd_addr];
         rd_inside_ff <= inside_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         red_ff        <= rd_inside_ff ? rd_data_ff[7:0]   : '0;
         green_ff      <= rd_inside_ff ? rd_data_ff[15:8]  : '0;
         blue_ff       <= rd_inside_ff ? rd_data_ff[23:16] : '0;
         inside_res_ff <= rd_inside_ff;
      end
   end

   assign out_red    = red_ff;
   assign out_green  = green_ff;
   assign out_blue   = blue_ff;
   assign inside_res = inside_res_ff;

endmodule
